### hdl/assert_macros.svh
// assertion macros shared by the renderer modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clk edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising clk edge, off while in reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### hdl/glr_pkg.sv
// shared types and constants of the guidance lightbar renderer
// no dependencies
package glr_pkg;

    // event kinds
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PACKET = 2'd1,
        OP_LINK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // display status codes
    typedef enum logic [1:0] {
        ST_NO_LINK  = 2'd0,
        ST_NO_DATA  = 2'd1,
        ST_AUTO_OFF = 2'd2,
        ST_TRACKING = 2'd3
    } status_t;

    // pixel colour codes
    typedef enum logic [2:0] {
        C_BLACK  = 3'd0,
        C_RED    = 3'd1,
        C_GREEN  = 3'd2,
        C_BLUE   = 3'd3,
        C_YELLOW = 3'd4
    } color_t;

    // shown status after reset, matches no real status
    localparam logic [2:0] SHOWN_INVALID = 3'd4;

    // packet checks
    localparam logic [31:0] PKT_HEADER    = 32'h8081_7FFE;
    localparam logic [7:0]  DIST_AUTO_OFF = 8'd255;
    localparam logic [8:0]  DIST_BIAS     = 9'd127;
    localparam logic [15:0] LEN_LIMIT     = 16'd1024;
    localparam logic [15:0] CNT_MAX       = 16'hFFFF;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = 8;

    // register indexes
    localparam logic [1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_REFRESH    = 2'd1;
    localparam logic [1:0] REG_ERR_PER_PX = 2'd2;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd3;

    // register reset values
    localparam logic [15:0] TIMEOUT_RST    = 16'd2000;
    localparam logic [15:0] REFRESH_RST    = 16'd1000;
    localparam logic [6:0]  ERR_PER_PX_RST = 7'd8;
    localparam logic [7:0]  BRIGHTNESS_RST = 8'd100;

    // configuration seen by the datapath
    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [15:0] refresh_ms;
        logic [6:0]  error_per_pixel;
        logic [7:0]  brightness;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic apply;
        logic commit;
        logic div_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ev_ignored;
        logic frame_due;
        logic out_free;
        logic pix_last;
    } sts_t;

endpackage

### hdl/guidance_lightbar_renderer_core.sv
// top level of the guidance lightbar renderer: register port, controller, datapath
// depends on glr_pkg, glr_ctrl, glr_datapath
//
//  channel   handshake            payload
//  events    in_valid / in_stall  op, link_up, header_word, distance_byte, packet_length
//  pixels    out_valid/out_stall  pixel_index, color, level, status_code, last
//  config    psel/penable/pready  paddr, pwdata, prdata
//
// an event is taken in S_IDLE and tested for a frame in the next cycle, in S_CHECK
// a frame then runs the divider for the bar length, then one pixel word per cycle while
// the receiver does not stall; the pixel output register sets the pace
// out_stall holds the current pixel word and pauses the frame; in_stall is high until done
// rst_n clears the display state and loads the register defaults at once
module guidance_lightbar_renderer_core #(
    parameter int PIXEL_COUNT = 35
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic        link_up,
    input  logic [31:0] header_word,
    input  logic [7:0]  distance_byte,
    input  logic [15:0] packet_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  pixel_index,
    output logic [2:0]  color,
    output logic [7:0]  level,
    output logic [1:0]  status_code,
    output logic        last
);
    import glr_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic wr_en;

    // register writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms      <= TIMEOUT_RST;
            cfg_reg.refresh_ms      <= REFRESH_RST;
            cfg_reg.error_per_pixel <= ERR_PER_PX_RST;
            cfg_reg.brightness      <= BRIGHTNESS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_TIMEOUT:    cfg_reg.timeout_ms      <= pwdata[15:0];
                REG_REFRESH:    cfg_reg.refresh_ms      <= pwdata[15:0];
                REG_ERR_PER_PX: cfg_reg.error_per_pixel <= pwdata[6:0];
                REG_BRIGHTNESS: cfg_reg.brightness      <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TIMEOUT:    prdata = {16'd0, cfg_reg.timeout_ms};
            REG_REFRESH:    prdata = {16'd0, cfg_reg.refresh_ms};
            REG_ERR_PER_PX: prdata = {25'd0, cfg_reg.error_per_pixel};
            REG_BRIGHTNESS: prdata = {24'd0, cfg_reg.brightness};
            default:        prdata = '0;
        endcase
    end

    glr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    glr_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .link_up       (link_up),
        .header_word   (header_word),
        .distance_byte (distance_byte),
        .packet_length (packet_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_index   (pixel_index),
        .color         (color),
        .level         (level),
        .status_code   (status_code),
        .last          (last)
    );

endmodule

### hdl/glr_ctrl.sv
// controller of the lightbar renderer: event accept, frame test, divide, pixel emit
// depends on glr_pkg and assert_macros.svh
`include "assert_macros.svh"

module glr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  glr_pkg::sts_t sts,
    output glr_pkg::cmd_t cmd
);
    import glr_pkg::*;

    localparam int CW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] div_cnt_reg;

    // commands decoded from state
    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.apply    = (state_reg == S_IDLE) && in_valid && !sts.ev_ignored;
    assign cmd.commit   = (state_reg == S_CHECK) && sts.frame_due;
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.emit     = (state_reg == S_EMIT) && sts.out_free;

    // state and divide step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.apply)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= sts.frame_due ? S_DIV : S_IDLE;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == CW'(DIV_STEPS - 1))
                        state_reg <= S_EMIT;
                    else
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (cmd.emit && sts.pix_last)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_frame_end_idle,
        (state_reg == S_EMIT && sts.out_free && sts.pix_last) |=> (state_reg == S_IDLE),
        "frame did not end after the last pixel")
    `ASSERT_IMPLY(a_div_leads_emit, state_reg == S_EMIT,
        $past(state_reg) == S_EMIT || $past(state_reg) == S_DIV,
        "emit entered without a divide")
    `ASSERT_CLK(a_commit_div,
        cmd.commit |=> (state_reg == S_DIV && div_cnt_reg == '0),
        "frame commit did not start the divider")

endmodule

### hdl/glr_datapath.sv
// datapath of the lightbar renderer: display state, counters, bar divider, pixel output
// depends on glr_pkg and assert_macros.svh
`include "assert_macros.svh"

module glr_datapath #(
    parameter int PIXEL_COUNT = 35
) (
    input  logic          clk,
    input  logic          rst_n,
    input  glr_pkg::cfg_t cfg,
    input  glr_pkg::cmd_t cmd,
    output glr_pkg::sts_t sts,
    input  logic [1:0]    op,
    input  logic          link_up,
    input  logic [31:0]   header_word,
    input  logic [7:0]    distance_byte,
    input  logic [15:0]   packet_length,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [5:0]    pixel_index,
    output logic [2:0]    color,
    output logic [7:0]    level,
    output logic [1:0]    status_code,
    output logic          last
);
    import glr_pkg::*;

    localparam logic [5:0]        LAST_PIX = 6'(PIXEL_COUNT - 1);
    localparam logic signed [7:0] CENTER   = 8'((PIXEL_COUNT - 1) / 2);

    // display state
    status_t            status_reg, status_next;
    logic [2:0]         shown_status_reg;
    logic signed [8:0]  track_error_reg, track_error_next;
    logic signed [8:0]  shown_error_reg;
    logic [15:0]        since_valid_reg, since_valid_next;
    logic [15:0]        since_refresh_reg, since_refresh_next;
    logic               link_reg, link_next;

    // divider and pixel counter
    logic [7:0]         quo_reg;
    logic [6:0]         rem_reg;
    logic [6:0]         dsr_reg;
    logic               neg_reg;
    logic [5:0]         pix_reg;

    // output word
    logic               out_valid_reg;
    logic [5:0]         pixel_index_reg;
    color_t             color_reg;
    logic [7:0]         level_reg;
    logic [1:0]         status_code_reg;
    logic               last_reg;

    logic               pkt_ok;
    logic [7:0]         trial;
    logic [7:0]         mag;
    logic signed [7:0]  lvl;
    logic signed [7:0]  bar_end;
    logic signed [7:0]  pix_s;
    color_t             end_color;
    color_t             pix_color;
    logic [8:0]         err_abs;

    // event update with timeout check
    assign pkt_ok = link_reg && (packet_length != 16'd0) && (packet_length < LEN_LIMIT)
                    && (header_word == PKT_HEADER);

    always_comb
    begin
        status_next        = status_reg;
        track_error_next   = track_error_reg;
        since_valid_next   = since_valid_reg;
        since_refresh_next = since_refresh_reg;
        link_next          = link_reg;
        case (op_t'(op))
            OP_TICK:
            begin
                if (since_valid_reg != CNT_MAX)
                    since_valid_next = since_valid_reg + 16'd1;
                if (since_refresh_reg != CNT_MAX)
                    since_refresh_next = since_refresh_reg + 16'd1;
            end
            OP_LINK:
            begin
                if (!link_reg && link_up)
                    status_next = ST_NO_DATA;
                else if (link_reg && !link_up)
                    status_next = ST_NO_LINK;
                link_next = link_up;
            end
            OP_PACKET:
            begin
                if (pkt_ok)
                begin
                    since_valid_next = '0;
                    if (distance_byte == DIST_AUTO_OFF)
                    begin
                        track_error_next = '0;
                        status_next      = ST_AUTO_OFF;
                    end
                    else
                    begin
                        track_error_next = $signed({1'b0, distance_byte}) - $signed(DIST_BIAS);
                        status_next      = ST_TRACKING;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (link_next && (since_valid_next > cfg.timeout_ms))
            status_next = ST_NO_DATA;
    end

    // status to controller
    assign sts.ev_ignored = (op_t'(op) == OP_NONE);
    assign sts.frame_due  = ({1'b0, status_reg} != shown_status_reg)
                            || (track_error_reg != shown_error_reg)
                            || (since_refresh_reg > cfg.refresh_ms);
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.pix_last   = (pix_reg == LAST_PIX);

    // divider trial subtract, magnitude of the error
    assign trial   = {rem_reg, quo_reg[7]};
    assign err_abs = track_error_reg[8] ? 9'(-track_error_reg) : 9'(track_error_reg);

    // bar level clamp
    assign mag     = ($signed({1'b0, quo_reg[6:0]}) > CENTER || quo_reg[7])
                     ? 8'(CENTER) : quo_reg;
    assign lvl     = neg_reg ? -$signed(mag) : $signed(mag);
    assign bar_end = lvl + CENTER;
    assign pix_s   = $signed({2'b00, pix_reg});

    // colour of the current pixel
    always_comb
    begin
        unique case (status_reg)
            ST_NO_LINK:  end_color = C_RED;
            ST_NO_DATA:  end_color = C_BLUE;
            ST_AUTO_OFF: end_color = C_GREEN;
            default:     end_color = C_BLACK;
        endcase
        if (status_reg == ST_TRACKING)
        begin
            if (pix_s == CENTER && lvl == 8'sd0)
                pix_color = C_YELLOW;
            else if (lvl < 8'sd0 && pix_s >= bar_end && pix_s < CENTER)
                pix_color = C_GREEN;
            else if (lvl > 8'sd0 && pix_s <= bar_end && pix_s > CENTER)
                pix_color = C_RED;
            else
                pix_color = C_BLACK;
        end
        else
        begin
            pix_color = (pix_reg == 6'd0 || pix_reg == LAST_PIX) ? end_color : C_BLACK;
        end
    end

    // display state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg        <= ST_NO_LINK;
            shown_status_reg  <= SHOWN_INVALID;
            track_error_reg   <= '0;
            shown_error_reg   <= '0;
            since_valid_reg   <= '0;
            since_refresh_reg <= '0;
            link_reg          <= 1'b0;
        end
        else if (cmd.apply)
        begin
            status_reg        <= status_next;
            track_error_reg   <= track_error_next;
            since_valid_reg   <= since_valid_next;
            since_refresh_reg <= since_refresh_next;
            link_reg          <= link_next;
        end
        else if (cmd.commit)
        begin
            since_refresh_reg <= '0;
            shown_status_reg  <= {1'b0, status_reg};
            shown_error_reg   <= track_error_reg;
        end
    end

    // restoring divider, one quotient bit a cycle, and pixel counter
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            quo_reg <= err_abs[7:0];
            rem_reg <= '0;
            dsr_reg <= (cfg.error_per_pixel == 7'd0) ? 7'd1 : cfg.error_per_pixel;
            neg_reg <= track_error_reg[8];
            pix_reg <= '0;
        end
        else
        begin
            if (cmd.div_step)
            begin
                if (trial >= {1'b0, dsr_reg})
                begin
                    rem_reg <= 7'(trial - {1'b0, dsr_reg});
                    quo_reg <= {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[6:0];
                    quo_reg <= {quo_reg[6:0], 1'b0};
                end
            end
            if (cmd.emit)
                pix_reg <= pix_reg + 6'd1;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_index_reg <= pix_reg;
            color_reg       <= pix_color;
            level_reg       <= cfg.brightness;
            status_code_reg <= status_reg;
            last_reg        <= (pix_reg == LAST_PIX);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign color       = color_reg;
    assign level       = level_reg;
    assign status_code = status_code_reg;
    assign last        = last_reg;

    `ASSERT_IMPLY(a_last_index, out_valid_reg && last_reg, pixel_index_reg == LAST_PIX,
        "last flag on a pixel other than the final one")
    `ASSERT_IMPLY(a_no_overwrite, cmd.emit, !(out_valid_reg && out_stall),
        "pixel loaded over a stalled word")
    `ASSERT_CLK(a_commit_shown,
        cmd.commit |=> (shown_status_reg == {1'b0, status_reg} && since_refresh_reg == '0),
        "frame commit did not record the shown status")

endmodule

### bench/guidance_lightbar_renderer_core_tb.sv
// self-checking bench for the guidance lightbar renderer core
// depends on glr_pkg and guidance_lightbar_renderer_core; event driver, pixel monitor, display model
module guidance_lightbar_renderer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int PIX       = 35;
    localparam int CENTER    = (PIX - 1) / 2;
    localparam int SETTLE    = 60;
    localparam int HOLD_LEN  = 400;
    localparam int SAT_TICKS = 8;

    // one event word as offered to the block
    typedef struct {
        op_t         op;
        logic        link;
        logic [31:0] hdr;
        logic [7:0]  dbyte;
        logic [15:0] len;
        bit          wait_drain;
    } event_t;

    // one pixel word as expected from the block
    typedef struct packed {
        logic [5:0] idx;
        color_t     col;
        logic [7:0] lvl;
        status_t    st;
        logic       lst;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic        link_up = 1'b0;
    logic [31:0] header_word = '0;
    logic [7:0]  distance_byte = '0;
    logic [15:0] packet_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  pixel_index;
    logic [2:0]  color;
    logic [7:0]  level;
    logic [1:0]  status_code;
    logic        last;

    // bench bookkeeping
    event_t event_q[$];
    pixel_t frame_q[$];
    int     events_pushed = 0;
    int     events_taken = 0;
    int     fail_count = 0;
    int     hold_req = 0;
    bit     quiet = 1'b0;
    logic   ev_taken = 1'b0;

    // display model state
    cfg_t        cfg_shadow;
    status_t     cur_status;
    logic [2:0]  shown_status;
    int          track_err;
    int          shown_err;
    logic [15:0] since_valid;
    logic [15:0] since_refresh;
    logic        link_on;

    guidance_lightbar_renderer_core #(
        .PIXEL_COUNT(PIX)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .link_up(link_up),
        .header_word(header_word),
        .distance_byte(distance_byte),
        .packet_length(packet_length),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_index(pixel_index),
        .color(color),
        .level(level),
        .status_code(status_code),
        .last(last)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // apply one event to the display model and queue the frame it causes
    function automatic void advance_display(op_t kind, logic up, logic [31:0] hdr,
                                            logic [7:0] dbyte, logic [15:0] len);
        int     div;
        int     lvl;
        int     n;
        color_t endc;
        color_t c;
        pixel_t px;
        if (kind == OP_NONE)
            return;
        case (kind)
            OP_TICK:
            begin
                if (since_valid != CNT_MAX)
                    since_valid++;
                if (since_refresh != CNT_MAX)
                    since_refresh++;
            end
            OP_LINK:
            begin
                if (!link_on && up)
                    cur_status = ST_NO_DATA;
                else if (link_on && !up)
                    cur_status = ST_NO_LINK;
                link_on = up;
            end
            default:
            begin
                if (link_on && len >= 16'd1 && len < LEN_LIMIT && hdr == PKT_HEADER)
                begin
                    since_valid = '0;
                    if (dbyte == DIST_AUTO_OFF)
                    begin
                        track_err = 0;
                        cur_status = ST_AUTO_OFF;
                    end
                    else
                    begin
                        track_err = int'(dbyte) - int'(DIST_BIAS);
                        cur_status = ST_TRACKING;
                    end
                end
            end
        endcase

        // timeout only counts while the link is up
        if (link_on && since_valid > cfg_shadow.timeout_ms)
            cur_status = ST_NO_DATA;

        if ({1'b0, cur_status} == shown_status && track_err == shown_err &&
            since_refresh <= cfg_shadow.refresh_ms)
            return;
        since_refresh = '0;
        shown_status = {1'b0, cur_status};
        shown_err = track_err;

        // bar length, truncated toward zero and clamped to half the bar
        div = (cfg_shadow.error_per_pixel == '0) ? 1 : int'(cfg_shadow.error_per_pixel);
        lvl = track_err / div;
        if (lvl > CENTER)
            lvl = CENTER;
        if (lvl < -CENTER)
            lvl = -CENTER;
        n = lvl + CENTER;
        case (cur_status)
            ST_NO_LINK:  endc = C_RED;
            ST_NO_DATA:  endc = C_BLUE;
            ST_AUTO_OFF: endc = C_GREEN;
            default:     endc = C_BLACK;
        endcase
        for (int i = 0; i < PIX; i++)
        begin
            if (cur_status == ST_TRACKING)
            begin
                if (i == CENTER && i == n)
                    c = C_YELLOW;
                else if (lvl < 0 && i >= n && i < CENTER)
                    c = C_GREEN;
                else if (lvl > 0 && i <= n && i > CENTER)
                    c = C_RED;
                else
                    c = C_BLACK;
            end
            else
                c = (i == 0 || i == PIX - 1) ? endc : C_BLACK;
            px.idx = 6'(i);
            px.col = c;
            px.lvl = cfg_shadow.brightness;
            px.st = cur_status;
            px.lst = (i == PIX - 1);
            frame_q.push_back(px);
        end
    endfunction

    // pixel monitor, then model update for the event word taken at this edge
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            ev_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                got = {pixel_index, color_t'(color), level, status_t'(status_code), last};
                if (frame_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"unexpected pixel word: ",
                                  "idx %0d color %0d level %0d status %0d last %0d"},
                                 got.idx, got.col, got.lvl, got.st, got.lst);
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"pixel mismatch: expected ",
                                      "idx %0d color %0d level %0d status %0d last %0d, ",
                                      "got idx %0d color %0d level %0d status %0d last %0d"},
                                     want.idx, want.col, want.lvl, want.st, want.lst,
                                     got.idx, got.col, got.lvl, got.st, got.lst);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                events_taken++;
                advance_display(op_t'(op), link_up, header_word, distance_byte, packet_length);
            end
        end
    end

    // event driver: holds a stalled word, otherwise offers the next one or idles
    always @(negedge clk)
    begin
        event_t nxt;
        if (rst_n && !(in_valid && !ev_taken))
        begin
            if (event_q.size() > 0 && !(event_q[0].wait_drain && frame_q.size() > 0) &&
                (quiet || $urandom_range(99) >= 30))
            begin
                nxt = event_q.pop_front();
                in_valid <= 1'b1;
                op <= nxt.op;
                link_up <= nxt.link;
                header_word <= nxt.hdr;
                distance_byte <= nxt.dbyte;
                packet_length <= nxt.len;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // pixel receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        static int hold_seen = 0;
        static int hold_left = 0;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 30);
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_event(op_t kind, logic up, logic [31:0] hdr, logic [7:0] dbyte,
                              logic [15:0] len, bit drain);
        event_t e;
        e.op = kind;
        e.link = up;
        e.hdr = hdr;
        e.dbyte = dbyte;
        e.len = len;
        e.wait_drain = drain;
        event_q.push_back(e);
        events_pushed++;
    endtask

    // mostly well-formed packets and ticks, some link changes, broken packets and noise
    function automatic event_t rand_event();
        event_t e;
        int pick;
        e.op = OP_PACKET;
        e.link = 1'($urandom_range(1));
        e.hdr = PKT_HEADER;
        e.dbyte = 8'($urandom_range(255));
        e.len = 16'($urandom_range(1023, 1));
        e.wait_drain = 1'b0;
        pick = $urandom_range(99);
        if (pick < 10)
            e.dbyte = DIST_AUTO_OFF;
        if (pick >= 40 && pick < 72)
            e.op = OP_TICK;
        else if (pick >= 72 && pick < 82)
        begin
            e.op = OP_LINK;
            e.link = ($urandom_range(99) < 75);
        end
        else if (pick >= 82 && pick < 88)
            e.hdr = $urandom;
        else if (pick >= 88 && pick < 92)
            e.hdr = PKT_HEADER ^ (32'd1 << $urandom_range(31));
        else if (pick >= 92 && pick < 97)
            e.len = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 1024));
        else if (pick >= 97)
        begin
            e.op = OP_NONE;
            e.hdr = $urandom;
        end
        return e;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_TIMEOUT:    cfg_shadow.timeout_ms = val[15:0];
            REG_REFRESH:    cfg_shadow.refresh_ms = val[15:0];
            REG_ERR_PER_PX: cfg_shadow.error_per_pixel = val[6:0];
            default:        cfg_shadow.brightness = val[7:0];
        endcase
    endtask

    // wait for every word to be taken and every pixel to arrive, then let the core settle
    task automatic wait_idle();
        while (events_taken != events_pushed || frame_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // reprogram all registers while idle, then queue random events
    task automatic run_phase(logic [15:0] tmo, logic [15:0] rfr, logic [6:0] epp,
                             logic [7:0] bright, int count);
        event_t e;
        wait_idle();
        reg_write(REG_TIMEOUT, 32'(tmo));
        reg_write(REG_REFRESH, 32'(rfr));
        reg_write(REG_ERR_PER_PX, 32'(epp));
        reg_write(REG_BRIGHTNESS, 32'(bright));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        for (int i = 0; i < count; i++)
        begin
            e = rand_event();
            push_event(e.op, e.link, e.hdr, e.dbyte, e.len, i == count / 2);
        end
    endtask

    // stimulus and final verdict
    initial
    begin
        cfg_shadow.timeout_ms = TIMEOUT_RST;
        cfg_shadow.refresh_ms = REFRESH_RST;
        cfg_shadow.error_per_pixel = ERR_PER_PX_RST;
        cfg_shadow.brightness = BRIGHTNESS_RST;
        cur_status = ST_NO_LINK;
        shown_status = SHOWN_INVALID;
        track_err = 0;
        shown_err = 0;
        since_valid = '0;
        since_refresh = '0;
        link_on = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed events under the reset register values
        push_event(OP_NONE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
        push_event(OP_TICK, 1'b0, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd100, 16'd20, 1'b0);
        push_event(OP_LINK, 1'b0, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_LINK, 1'b1, 32'h0, 8'h0, 16'h0, 1'b1);
        push_event(OP_LINK, 1'b1, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, DIST_AUTO_OFF, 16'd1, 1'b0);
        push_event(OP_PACKET, 1'b1, PKT_HEADER, 8'd0, 16'd1023, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd254, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd127, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd130, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd120, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd110, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, 32'h8081_7FFF, 8'd0, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, ~PKT_HEADER, 8'd0, 16'd64, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd0, 16'd0, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd0, LEN_LIMIT, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd0, 16'hFFFF, 1'b0);
        push_event(OP_PACKET, 1'b0, 32'hFFFF_FFFF, 8'd0, 16'd5, 1'b0);
        push_event(OP_NONE, 1'b0, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_LINK, 1'b0, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_PACKET, 1'b1, PKT_HEADER, 8'd40, 16'd64, 1'b0);
        push_event(OP_LINK, 1'b1, 32'h0, 8'h0, 16'h0, 1'b0);

        // short timeout and refresh, finest bar steps, full brightness
        run_phase(16'd5, 16'd12, 7'd1, 8'd255, 32);

        // pile frames up behind a long receiver hold-off
        push_event(OP_LINK, 1'b1, 32'h0, 8'h0, 16'h0, 1'b0);
        for (int i = 0; i < 8; i++)
            push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'(20 * i + 5), 16'd100, 1'b0);
        @(posedge clk);
        hold_req++;

        // smallest timeout and refresh, coarsest bar steps, zero brightness
        run_phase(16'd1, 16'd1, 7'd127, 8'd0, 32);

        // zero step treated as one, with no idling on either side
        quiet = 1'b1;
        run_phase(16'd20, 16'd3, 7'd0, 8'($urandom_range(255)), 32);

        // the largest periods stay quiet over a short run of ticks
        run_phase(16'hFFFF, 16'hFFFF, 7'($urandom_range(127, 1)), 8'($urandom_range(255)), 0);
        push_event(OP_LINK, 1'b1, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd90, 16'd200, 1'b0);
        for (int i = 0; i < SAT_TICKS; i++)
            push_event(OP_TICK, 1'b0, 32'h0, 8'h0, 16'h0, 1'b0);
        push_event(OP_PACKET, 1'b0, PKT_HEADER, 8'd200, 16'd200, 1'b0);
        wait_idle();
        quiet = 1'b0;

        // random register values
        run_phase(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
                  7'($urandom_range(127, 1)), 8'($urandom_range(255)), 32);

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
